// ----- rtl/core/rgb_fade_tick_sequencer_assert.svh -----
// Assertion macros shared by the RGB fade tick sequencer modules.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef RGB_FADE_TICK_SEQUENCER_ASSERT_SVH
`define RGB_FADE_TICK_SEQUENCER_ASSERT_SVH

// The condition holds at every clock edge.
`define RFTS_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define RFTS_CHECK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define RFTS_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/rfts_pkg.sv -----
// Types, constants and small helper functions for the RGB fade tick sequencer.
// Used by every module of the block; depends on nothing.
package rfts_pkg;

	localparam int unsigned LEVEL_W    = 8;
	localparam int unsigned DUTY_W     = 16;
	localparam int unsigned PERIOD_W   = 16;
	localparam int unsigned FIX_SHIFT  = 12;
	localparam int unsigned QUO_W      = PERIOD_W + FIX_SHIFT;
	localparam int unsigned GAIN_Q_W   = LEVEL_W + FIX_SHIFT;
	localparam int unsigned BRIGHT_Q_W = FIX_SHIFT + 1;
	localparam int unsigned ACC_W      = 32;
	localparam int unsigned PROD_W     = ACC_W + QUO_W;
	localparam int unsigned DIV_BITS   = 4;
	localparam int unsigned DIV_CYCLES = QUO_W / DIV_BITS;
	localparam int unsigned NUM_LANES  = 3;
	localparam int unsigned TICK_W     = 5;
	localparam int unsigned WHEEL_W    = 11;
	localparam int unsigned REG_IDX_W  = 3;

	localparam logic [1:0] MODE_FADE   = 2'd1;
	localparam logic [1:0] MODE_STROBE = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_LIGHT_MODE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PWM_PERIOD = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SCALE_MAX  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RED_GAIN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GREEN_GAIN = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BLUE_GAIN  = 3'd5;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd160;
	localparam logic [LEVEL_W-1:0]  SCALE_RESET  = 8'd31;
	localparam logic [LEVEL_W-1:0]  GAIN_RESET   = 8'd29;

	localparam logic [TICK_W-1:0] TICK_SLOT0 = 5'd5;
	localparam logic [TICK_W-1:0] TICK_SLOT1 = 5'd10;
	localparam logic [TICK_W-1:0] TICK_SLOT2 = 5'd15;
	localparam logic [TICK_W-1:0] TICK_TOP   = 5'd20;

	localparam logic [WHEEL_W-1:0] WHEEL_LAST = 11'd1530;

	typedef struct packed {
		logic [LEVEL_W-1:0] r;
		logic [LEVEL_W-1:0] g;
		logic [LEVEL_W-1:0] b;
	} rgb_t;

	// One classified tick as it travels from the front end to the back end.
	typedef struct packed {
		logic               measure_temp;
		logic [1:0]         temp_slot;
		logic               new_sample;
		logic               value_changed;
		logic               fade;
		rgb_t               level;
		logic [LEVEL_W-1:0] brightness;
	} item_t;

	// Scaling registers as seen by the back end; lane 0 red, 1 green, 2 blue.
	typedef struct packed {
		logic [PERIOD_W-1:0]                pwm_period;
		logic [LEVEL_W-1:0]                 scale_max;
		logic [NUM_LANES-1:0][LEVEL_W-1:0]  gain;
	} cfg_t;

	// Piecewise-linear hue wheel: six ramps of 255 steps each.
	function automatic rgb_t wheel_levels(input logic [WHEEL_W-1:0] p);
		rgb_t               c;
		logic [WHEEL_W-1:0] d;
		c = '0;
		d = '0;
		if (p <= 11'd255) begin
			c.r = '1;
			c.g = p[LEVEL_W-1:0];
		end else if (p <= 11'd510) begin
			c.g = '1;
			d   = 11'd510 - p;
			c.r = d[LEVEL_W-1:0];
		end else if (p <= 11'd765) begin
			c.g = '1;
			d   = p - 11'd510;
			c.b = d[LEVEL_W-1:0];
		end else if (p <= 11'd1020) begin
			c.b = '1;
			d   = 11'd1020 - p;
			c.g = d[LEVEL_W-1:0];
		end else if (p <= 11'd1275) begin
			c.b = '1;
			d   = p - 11'd1020;
			c.r = d[LEVEL_W-1:0];
		end else if (p <= WHEEL_LAST) begin
			c.r = '1;
			d   = WHEEL_LAST - p;
			c.b = d[LEVEL_W-1:0];
		end else begin
			c.r = '1;
		end
		return c;
	endfunction

	// brightness * 4096 / 255, truncated. Since 4096 = 16 * 255 + 16, this is
	// 16*b plus (16*b)/255, and the small quotient uses the usual x/255 trick.
	function automatic logic [BRIGHT_Q_W-1:0] bright_factor(input logic [LEVEL_W-1:0] b);
		logic [FIX_SHIFT-1:0]  x;
		logic [BRIGHT_Q_W-1:0] s;
		x = {b, 4'b0000};
		s = {1'b0, x} + BRIGHT_Q_W'(x[FIX_SHIFT-1:LEVEL_W]) + BRIGHT_Q_W'(1);
		return {1'b0, x} + BRIGHT_Q_W'(s[BRIGHT_Q_W-1:LEVEL_W]);
	endfunction

endpackage

// ----- rtl/core/rfts_fifo.sv -----
// Small register-based queue that decouples the tick front end from the back end.
// Depends on rfts_pkg for the item type.
`include "rgb_fade_tick_sequencer_assert.svh"

module rfts_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rfts_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output rfts_pkg::item_t head_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	rfts_pkg::item_t   entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`RFTS_CHECK_IMPL(a_no_pop_when_empty, pop, count_q != '0, "queue popped while empty")

endmodule

// ----- rtl/core/rfts_div.sv -----
// Iterative restoring divider for the fixed-point scale factors.
// Produces four quotient bits per cycle; depends on rfts_pkg for widths.
module rfts_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rfts_pkg::QUO_W-1:0]     dividend,
	input  logic [rfts_pkg::LEVEL_W-1:0]   divisor,
	output logic                           done,
	output logic [rfts_pkg::QUO_W-1:0]     quotient
);

	localparam int unsigned CNT_W = $clog2(rfts_pkg::DIV_CYCLES);

	logic                           busy_q;
	logic                           done_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [rfts_pkg::QUO_W-1:0]     work_q;
	logic [rfts_pkg::LEVEL_W-1:0]   rem_q;
	logic [rfts_pkg::QUO_W-1:0]     work_d;
	logic [rfts_pkg::LEVEL_W-1:0]   rem_d;
	logic [rfts_pkg::LEVEL_W:0]     trial;

	// The work register shifts the dividend out at the top and the quotient in
	// at the bottom, so it holds the quotient once all bits have passed.
	always_comb begin
		work_d = work_q;
		rem_d  = rem_q;
		trial  = '0;
		for (int i = 0; i < rfts_pkg::DIV_BITS; i++) begin
			trial  = {rem_d, work_d[rfts_pkg::QUO_W-1]};
			work_d = {work_d[rfts_pkg::QUO_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				trial     = trial - {1'b0, divisor};
				work_d[0] = 1'b1;
			end
			rem_d = trial[rfts_pkg::LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(rfts_pkg::DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

// ----- rtl/core/rfts_front.sv -----
// Front end: accepts ticks, runs the tick divider and the hue wheel, and
// classifies each tick into a queue item. Depends on rfts_pkg.
`include "rgb_fade_tick_sequencer_assert.svh"

module rfts_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rfts_pkg::LEVEL_W-1:0] brightness,
	input  logic [1:0]                   light_mode,
	input  logic                         q_full,
	output logic                         q_push,
	output rfts_pkg::item_t              q_item
);

	logic [rfts_pkg::TICK_W-1:0]  tick_q;
	logic [rfts_pkg::WHEEL_W-1:0] wheel_q;
	logic [rfts_pkg::WHEEL_W-1:0] wheel_next;
	logic                         fade;
	logic                         at_top;
	logic                         accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;

	assign fade   = (light_mode == rfts_pkg::MODE_FADE);
	assign at_top = (tick_q == rfts_pkg::TICK_TOP);

	assign wheel_next = (wheel_q > rfts_pkg::WHEEL_LAST) ? '0 : wheel_q + 1'b1;

	always_comb begin
		q_item               = '0;
		q_item.new_sample    = at_top;
		q_item.value_changed = fade || (at_top && light_mode == rfts_pkg::MODE_STROBE);
		q_item.fade          = fade;
		q_item.level         = rfts_pkg::wheel_levels(wheel_next);
		q_item.brightness    = brightness;
		unique case (tick_q)
			rfts_pkg::TICK_SLOT0: begin
				q_item.measure_temp = 1'b1;
				q_item.temp_slot    = 2'd0;
			end
			rfts_pkg::TICK_SLOT1: begin
				q_item.measure_temp = 1'b1;
				q_item.temp_slot    = 2'd1;
			end
			rfts_pkg::TICK_SLOT2: begin
				q_item.measure_temp = 1'b1;
				q_item.temp_slot    = 2'd2;
			end
			rfts_pkg::TICK_TOP: begin
				q_item.measure_temp = 1'b1;
				q_item.temp_slot    = 2'd3;
			end
			default: begin
				q_item.measure_temp = 1'b0;
				q_item.temp_slot    = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			wheel_q <= '0;
		end else if (accept) begin
			tick_q <= at_top ? '0 : tick_q + 1'b1;
			if (fade) begin
				wheel_q <= wheel_next;
			end
		end
	end

	`RFTS_CHECK(a_tick_in_range, tick_q <= rfts_pkg::TICK_TOP, "tick divider left 0..20")
	`RFTS_CHECK_NEXT(a_wheel_holds, accept && !fade, $stable(wheel_q), "wheel moved outside fade")

endmodule

// ----- rtl/core/rfts_back.sv -----
// Back end: computes the three PWM duties of a queued tick and holds the result
// beat in the output register. Depends on rfts_pkg and rfts_div.
`include "rgb_fade_tick_sequencer_assert.svh"

module rfts_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rfts_pkg::cfg_t                cfg,
	input  logic                          cfg_write,
	input  logic                          q_valid,
	input  rfts_pkg::item_t               q_item,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          measure_temp,
	output logic [1:0]                    temp_slot,
	output logic                          new_sample,
	output logic                          value_changed,
	output logic [rfts_pkg::DUTY_W-1:0]   red_duty,
	output logic [rfts_pkg::DUTY_W-1:0]   green_duty,
	output logic [rfts_pkg::DUTY_W-1:0]   blue_duty
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_MUL  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	localparam logic [1:0] MUL_LEVEL  = 2'd0;
	localparam logic [1:0] MUL_GAIN   = 2'd1;
	localparam logic [1:0] MUL_BRIGHT = 2'd2;

	localparam logic [1:0] SEL_PERIOD = 2'd0;
	localparam logic [1:0] SEL_LAST   = 2'd3;

	localparam int unsigned LANE_W = rfts_pkg::NUM_LANES;

	logic [1:0]                             state_q;
	logic [1:0]                             mul_step_q;
	logic [1:0]                             div_sel_q;
	logic [1:0]                             div_sel_start;
	logic                                   dirty_q;
	rfts_pkg::item_t                        item_q;
	logic [rfts_pkg::QUO_W-1:0]             f_period_q;
	logic [LANE_W-1:0][rfts_pkg::GAIN_Q_W-1:0] f_gain_q;
	logic [rfts_pkg::BRIGHT_Q_W-1:0]        f_bright_q;
	logic [LANE_W-1:0][rfts_pkg::ACC_W-1:0] acc_q;
	logic [LANE_W-1:0][rfts_pkg::DUTY_W-1:0] duty_q;

	logic                                   out_valid_q;
	logic                                   out_measure_q;
	logic [1:0]                             out_slot_q;
	logic                                   out_new_q;
	logic                                   out_changed_q;
	logic [LANE_W-1:0][rfts_pkg::DUTY_W-1:0] out_duty_q;

	logic                                   out_load;
	logic                                   take;
	logic                                   div_start;
	logic                                   div_done;
	logic [rfts_pkg::QUO_W-1:0]             div_quotient;
	logic [rfts_pkg::QUO_W-1:0]             div_dividend;
	logic [rfts_pkg::LEVEL_W-1:0]           div_divisor;
	logic [LANE_W-1:0][rfts_pkg::LEVEL_W-1:0] lane_level;
	logic [LANE_W-1:0][rfts_pkg::ACC_W-1:0] op_a;
	logic [LANE_W-1:0][rfts_pkg::QUO_W-1:0] op_b;
	logic [LANE_W-1:0][rfts_pkg::PROD_W-1:0] prod;
	logic [LANE_W-1:0][rfts_pkg::DUTY_W-1:0] sat;

	assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign take     = q_valid && ((state_q == S_IDLE) || out_load);
	assign q_pop    = take;

	// Quotient selection: the period factor first, then one factor per gain.
	assign div_sel_start = take ? SEL_PERIOD : div_sel_q + 1'b1;
	assign div_start     = (take && q_item.fade && dirty_q)
		|| ((state_q == S_DIV) && div_done && (div_sel_q != SEL_LAST));
	assign div_divisor   = (cfg.scale_max == '0) ? rfts_pkg::LEVEL_W'(1) : cfg.scale_max;

	always_comb begin
		if (div_sel_start == SEL_PERIOD) begin
			div_dividend = {cfg.pwm_period, rfts_pkg::FIX_SHIFT'(0)};
		end else begin
			div_dividend = rfts_pkg::QUO_W'({cfg.gain[div_sel_start - 1'b1],
				rfts_pkg::FIX_SHIFT'(0)});
		end
	end

	rfts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign lane_level[0] = item_q.level.r;
	assign lane_level[1] = item_q.level.g;
	assign lane_level[2] = item_q.level.b;

	// One multiplier per lane, reused for the level, gain and brightness steps.
	always_comb begin
		for (int l = 0; l < LANE_W; l++) begin
			unique case (mul_step_q)
				MUL_LEVEL: begin
					op_a[l] = rfts_pkg::ACC_W'(lane_level[l]);
					op_b[l] = f_period_q;
				end
				MUL_GAIN: begin
					op_a[l] = acc_q[l];
					op_b[l] = rfts_pkg::QUO_W'(f_gain_q[l]);
				end
				default: begin
					op_a[l] = acc_q[l];
					op_b[l] = rfts_pkg::QUO_W'(f_bright_q);
				end
			endcase
			prod[l] = rfts_pkg::PROD_W'(op_a[l]) * rfts_pkg::PROD_W'(op_b[l]);
			if (prod[l][rfts_pkg::PROD_W-1:rfts_pkg::FIX_SHIFT+rfts_pkg::DUTY_W] != '0) begin
				sat[l] = '1;
			end else begin
				sat[l] = prod[l][rfts_pkg::FIX_SHIFT+rfts_pkg::DUTY_W-1:rfts_pkg::FIX_SHIFT];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q     <= q_item;
			f_bright_q <= rfts_pkg::bright_factor(q_item.brightness);
			duty_q     <= '0;
		end
		if ((state_q == S_DIV) && div_done) begin
			if (div_sel_q == SEL_PERIOD) begin
				f_period_q <= div_quotient;
			end else begin
				f_gain_q[div_sel_q - 1'b1] <= div_quotient[rfts_pkg::GAIN_Q_W-1:0];
			end
		end
		if (state_q == S_MUL) begin
			for (int l = 0; l < LANE_W; l++) begin
				acc_q[l] <= prod[l][rfts_pkg::FIX_SHIFT+rfts_pkg::ACC_W-1:rfts_pkg::FIX_SHIFT];
				if (mul_step_q == MUL_BRIGHT) begin
					duty_q[l] <= sat[l];
				end
			end
		end
		if (out_load) begin
			out_measure_q <= item_q.measure_temp;
			out_slot_q    <= item_q.temp_slot;
			out_new_q     <= item_q.new_sample;
			out_changed_q <= item_q.value_changed;
			out_duty_q    <= duty_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mul_step_q  <= MUL_LEVEL;
			div_sel_q   <= SEL_PERIOD;
			dirty_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				dirty_q <= 1'b1;
			end else if ((state_q == S_DIV) && div_done && (div_sel_q == SEL_LAST)) begin
				dirty_q <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (take) begin
				mul_step_q <= MUL_LEVEL;
				div_sel_q  <= SEL_PERIOD;
				if (!q_item.fade) begin
					state_q <= S_FIN;
				end else if (dirty_q) begin
					state_q <= S_DIV;
				end else begin
					state_q <= S_MUL;
				end
			end else begin
				unique case (state_q)
					S_IDLE: state_q <= S_IDLE;
					S_DIV: begin
						if (div_done) begin
							div_sel_q <= div_sel_q + 1'b1;
							if (div_sel_q == SEL_LAST) begin
								state_q <= S_MUL;
							end
						end
					end
					S_MUL: begin
						mul_step_q <= mul_step_q + 1'b1;
						if (mul_step_q == MUL_BRIGHT) begin
							state_q <= S_FIN;
						end
					end
					S_FIN: begin
						if (out_load) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign measure_temp  = out_measure_q;
	assign temp_slot     = out_slot_q;
	assign new_sample    = out_new_q;
	assign value_changed = out_changed_q;
	assign red_duty      = out_duty_q[0];
	assign green_duty    = out_duty_q[1];
	assign blue_duty     = out_duty_q[2];

	`RFTS_CHECK_IMPL(a_mul_fresh, state_q == S_MUL, !dirty_q, "multiply on stale scale factors")
	`RFTS_CHECK_IMPL(a_div_done_in_div, div_done, state_q == S_DIV, "divider finished outside S_DIV")

endmodule

// ----- rtl/core/rgb_fade_tick_sequencer.sv -----
// RGB hue-wheel fade tick sequencer, top level: config registers, front end, queue, back end.
// A fade tick runs three multiply steps per lane before it loads the output register; other
// ticks load it directly, one per cycle while out_stall is low. A new item is popped only as
// the last one loads the output; the first fade tick after a config write also waits for the
// four scale-factor divisions. Reset (arst_n low) clears the divider, wheel, queue and output
// beat and loads the register defaults; the scale factors are recomputed on first use.
module rgb_fade_tick_sequencer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rfts_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [rfts_pkg::PERIOD_W-1:0]        cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [rfts_pkg::LEVEL_W-1:0]         brightness,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 measure_temp,
	output logic [1:0]                           temp_slot,
	output logic                                 new_sample,
	output logic                                 value_changed,
	output logic [rfts_pkg::DUTY_W-1:0]          red_duty,
	output logic [rfts_pkg::DUTY_W-1:0]          green_duty,
	output logic [rfts_pkg::DUTY_W-1:0]          blue_duty
);

	// The front end owns the tick divider and the wheel position. It takes a
	// tick whenever the queue has room, so it never waits for the multipliers.
	// The back end pops one item at a time, scales the three wheel levels in
	// fixed point, and parks the finished beat in its output register. The
	// period and gain factors depend only on configuration, so they are divided
	// once after any register write and reused for every later tick.

	logic [1:0]       light_mode_q;
	rfts_pkg::cfg_t   cfg_q;

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_not_empty;
	rfts_pkg::item_t  q_push_item;
	rfts_pkg::item_t  q_head_item;

	// Configuration writes land directly; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_mode_q     <= '0;
			cfg_q.pwm_period <= rfts_pkg::PERIOD_RESET;
			cfg_q.scale_max  <= rfts_pkg::SCALE_RESET;
			cfg_q.gain       <= {rfts_pkg::NUM_LANES{rfts_pkg::GAIN_RESET}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				rfts_pkg::REG_LIGHT_MODE: light_mode_q <= cfg_wdata[1:0];
				rfts_pkg::REG_PWM_PERIOD: cfg_q.pwm_period <= cfg_wdata;
				rfts_pkg::REG_SCALE_MAX:  cfg_q.scale_max <= cfg_wdata[rfts_pkg::LEVEL_W-1:0];
				rfts_pkg::REG_RED_GAIN:   cfg_q.gain[0] <= cfg_wdata[rfts_pkg::LEVEL_W-1:0];
				rfts_pkg::REG_GREEN_GAIN: cfg_q.gain[1] <= cfg_wdata[rfts_pkg::LEVEL_W-1:0];
				rfts_pkg::REG_BLUE_GAIN:  cfg_q.gain[2] <= cfg_wdata[rfts_pkg::LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Classification: measure and new-sample pulses, value-changed flag and
	// the wheel levels for the advanced position.
	rfts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.brightness (brightness),
		.light_mode (light_mode_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (q_push_item)
	);

	// The queue lets the front keep taking ticks while the back end multiplies
	// or waits on a stalled output beat.
	rfts_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_item (q_head_item)
	);

	// Duty computation and the output register. Any register write marks the
	// cached scale factors stale.
	rfts_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cfg_write     (cfg_we),
		.q_valid       (q_not_empty),
		.q_item        (q_head_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.measure_temp  (measure_temp),
		.temp_slot     (temp_slot),
		.new_sample    (new_sample),
		.value_changed (value_changed),
		.red_duty      (red_duty),
		.green_duty    (green_duty),
		.blue_duty     (blue_duty)
	);

endmodule

// ----- tb/tb_rgb_fade_tick_sequencer.sv -----
// Self-checking testbench for rgb_fade_tick_sequencer: divider pulses, hue wheel and PWM duties.
// Depends on rfts_pkg and the RTL top level; an internal predictor checks every output beat.
module tb_rgb_fade_tick_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	// The two light modes that behave alike: no wheel motion, no duties.
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// Cycles allowed after the last result before a register write or the end.
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned FADE_TICKS    = 192;
	localparam int unsigned OTHER_TICKS   = 10;

	typedef struct {
		logic                        measure_temp;
		logic [1:0]                  temp_slot;
		logic                        new_sample;
		logic                        value_changed;
		logic [rfts_pkg::DUTY_W-1:0] red;
		logic [rfts_pkg::DUTY_W-1:0] green;
		logic [rfts_pkg::DUTY_W-1:0] blue;
	} tick_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [rfts_pkg::REG_IDX_W-1:0] cfg_index = rfts_pkg::REG_LIGHT_MODE;
	logic [rfts_pkg::PERIOD_W-1:0]  cfg_wdata = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [rfts_pkg::LEVEL_W-1:0]   brightness = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic                           measure_temp;
	logic [1:0]                     temp_slot;
	logic                           new_sample;
	logic                           value_changed;
	logic [rfts_pkg::DUTY_W-1:0]    red_duty;
	logic [rfts_pkg::DUTY_W-1:0]    green_duty;
	logic [rfts_pkg::DUTY_W-1:0]    blue_duty;

	// Brightness of ticks not yet accepted, and results still owed by the block.
	logic [rfts_pkg::LEVEL_W-1:0] tick_q [$];
	tick_result_t                 owed_q [$];

	// Predictor state: a private copy of the registers, the divider and the wheel.
	logic [1:0]                    m_mode;
	logic [rfts_pkg::PERIOD_W-1:0] m_period;
	logic [rfts_pkg::LEVEL_W-1:0]  m_scale;
	logic [rfts_pkg::LEVEL_W-1:0]  m_gain [rfts_pkg::NUM_LANES];
	logic [rfts_pkg::TICK_W-1:0]   div_cnt;
	logic [rfts_pkg::WHEEL_W-1:0]  hue_pos;

	// Handshake flags sampled at the rising edge, used by the driver at the falling edge.
	bit          in_taken;
	bit          out_taken;
	bit          quiet;
	int unsigned in_gap;
	int unsigned stall_left;
	int unsigned n_fail;

	always #5ns clk = ~clk;

	rgb_fade_tick_sequencer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.brightness   (brightness),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.measure_temp (measure_temp),
		.temp_slot    (temp_slot),
		.new_sample   (new_sample),
		.value_changed(value_changed),
		.red_duty     (red_duty),
		.green_duty   (green_duty),
		.blue_duty    (blue_duty)
	);

	// The wheel is six linear ramps of 255 steps; anything past the last ramp is pure red.
	function automatic rfts_pkg::rgb_t hue_color(input logic [rfts_pkg::WHEEL_W-1:0] pos);
		rfts_pkg::rgb_t c;
		int unsigned    p;
		p = pos;
		c = '0;
		if (p <= 255) begin
			c.r = 8'hFF;
			c.g = rfts_pkg::LEVEL_W'(p);
		end else if (p <= 510) begin
			c.g = 8'hFF;
			c.r = rfts_pkg::LEVEL_W'(510 - p);
		end else if (p <= 765) begin
			c.g = 8'hFF;
			c.b = rfts_pkg::LEVEL_W'(p - 510);
		end else if (p <= 1020) begin
			c.b = 8'hFF;
			c.g = rfts_pkg::LEVEL_W'(1020 - p);
		end else if (p <= 1275) begin
			c.b = 8'hFF;
			c.r = rfts_pkg::LEVEL_W'(p - 1020);
		end else if (p <= 1530) begin
			c.r = 8'hFF;
			c.b = rfts_pkg::LEVEL_W'(1530 - p);
		end else begin
			c.r = 8'hFF;
		end
		return c;
	endfunction

	// Three chained 12-bit fixed-point scalings; a zero scale_max divides by one and the
	// final duty saturates at the top of the 16-bit range.
	function automatic logic [rfts_pkg::DUTY_W-1:0] lane_duty(
			input logic [rfts_pkg::LEVEL_W-1:0] level,
			input logic [rfts_pkg::LEVEL_W-1:0] gain,
			input logic [rfts_pkg::LEVEL_W-1:0] bright);
		logic [63:0] div;
		logic [63:0] d;
		div = (m_scale == '0) ? 64'd1 : 64'(m_scale);
		d = (64'(level) * ((64'(m_period) << 12) / div)) >> 12;
		d = (d * ((64'(gain) << 12) / div)) >> 12;
		d = (d * ((64'(bright) << 12) / 64'd255)) >> 12;
		return (d > 64'hFFFF) ? 16'hFFFF : d[rfts_pkg::DUTY_W-1:0];
	endfunction

	// Works out the result of one tick and advances the divider and the wheel.
	function automatic tick_result_t advance_sequencer(input logic [rfts_pkg::LEVEL_W-1:0] bright);
		tick_result_t   res;
		rfts_pkg::rgb_t c;
		res = '{default: '0};
		case (div_cnt)
			rfts_pkg::TICK_SLOT0: begin
				res.measure_temp = 1'b1;
				res.temp_slot    = 2'd0;
			end
			rfts_pkg::TICK_SLOT1: begin
				res.measure_temp = 1'b1;
				res.temp_slot    = 2'd1;
			end
			rfts_pkg::TICK_SLOT2: begin
				res.measure_temp = 1'b1;
				res.temp_slot    = 2'd2;
			end
			rfts_pkg::TICK_TOP: begin
				res.measure_temp = 1'b1;
				res.temp_slot    = 2'd3;
			end
			default: ;
		endcase
		if (div_cnt == rfts_pkg::TICK_TOP) begin
			res.new_sample = 1'b1;
			div_cnt = '0;
			if (m_mode == rfts_pkg::MODE_STROBE)
				res.value_changed = 1'b1;
		end else begin
			div_cnt = div_cnt + 1'b1;
		end
		if (m_mode == rfts_pkg::MODE_FADE) begin
			hue_pos = (hue_pos > rfts_pkg::WHEEL_LAST) ? '0 : hue_pos + 1'b1;
			res.value_changed = 1'b1;
			c = hue_color(hue_pos);
			res.red   = lane_duty(c.r, m_gain[0], bright);
			res.green = lane_duty(c.g, m_gain[1], bright);
			res.blue  = lane_duty(c.b, m_gain[2], bright);
		end
		return res;
	endfunction

	task automatic compare(input string field, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
			n_fail++;
		end
	endtask

	// Monitor: checks each output beat against the oldest owed result, mirrors register
	// writes, and predicts the result of each accepted input beat. Checking comes first so
	// that a result can never be matched against a prediction made in the same cycle.
	always @(posedge clk) begin
		tick_result_t want;
		if (!arst_n) begin
			m_mode    = MODE_IDLE;
			m_period  = rfts_pkg::PERIOD_RESET;
			m_scale   = rfts_pkg::SCALE_RESET;
			m_gain[0] = rfts_pkg::GAIN_RESET;
			m_gain[1] = rfts_pkg::GAIN_RESET;
			m_gain[2] = rfts_pkg::GAIN_RESET;
			div_cnt   = '0;
			hue_pos   = '0;
			in_taken  = 1'b0;
			out_taken = 1'b0;
		end else begin
			out_taken = out_valid && !out_stall;
			if (out_taken) begin
				if (owed_q.size() == 0) begin
					$display("%0t ns: output beat with nothing owed: slot %0d duties %0d %0d %0d",
						$time, temp_slot, red_duty, green_duty, blue_duty);
					n_fail++;
				end else begin
					want = owed_q.pop_front();
					compare("measure_temp", want.measure_temp, measure_temp);
					compare("temp_slot", want.temp_slot, temp_slot);
					compare("new_sample", want.new_sample, new_sample);
					compare("value_changed", want.value_changed, value_changed);
					compare("red_duty", want.red, red_duty);
					compare("green_duty", want.green, green_duty);
					compare("blue_duty", want.blue, blue_duty);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					rfts_pkg::REG_LIGHT_MODE: m_mode    = cfg_wdata[1:0];
					rfts_pkg::REG_PWM_PERIOD: m_period  = cfg_wdata;
					rfts_pkg::REG_SCALE_MAX:  m_scale   = cfg_wdata[rfts_pkg::LEVEL_W-1:0];
					rfts_pkg::REG_RED_GAIN:   m_gain[0] = cfg_wdata[rfts_pkg::LEVEL_W-1:0];
					rfts_pkg::REG_GREEN_GAIN: m_gain[1] = cfg_wdata[rfts_pkg::LEVEL_W-1:0];
					rfts_pkg::REG_BLUE_GAIN:  m_gain[2] = cfg_wdata[rfts_pkg::LEVEL_W-1:0];
					default: ;
				endcase
			end
			in_taken = in_valid && !in_stall;
			if (in_taken) begin
				owed_q.push_back(advance_sequencer(brightness));
				void'(tick_q.pop_front());
			end
		end
	end

	// Driver: presents the oldest pending tick after a random gap and holds it while the
	// block stalls; draws a random stall before each output beat. In quiet phases both
	// sides run back to back. Each signal gets at most one assignment per falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken)
				in_gap = quiet ? 0 : $urandom_range(0, 9);
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				in_valid   <= 1'b1;
				brightness <= tick_q[0];
			end else begin
				in_valid <= 1'b0;
			end
			if (out_taken)
				stall_left = quiet ? 0 : $urandom_range(0, 9);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Waits until every tick is accepted and every result has come, then lets the block
	// finish any internal work. Polled at the falling edge, where both queues are stable.
	task automatic drain();
		while (tick_q.size() != 0 || owed_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [rfts_pkg::REG_IDX_W-1:0] idx,
			input logic [rfts_pkg::PERIOD_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Register values lean on the extremes, including the zero scale_max special case.
	function automatic logic [rfts_pkg::LEVEL_W-1:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'h01;
			2: return 8'hFF;
			default: return rfts_pkg::LEVEL_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [rfts_pkg::PERIOD_W-1:0] pick_period();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'h0001;
			2: return 16'hFFFF;
			3: return rfts_pkg::PERIOD_W'($urandom_range(1, 400));
			default: return rfts_pkg::PERIOD_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [rfts_pkg::LEVEL_W-1:0] pick_brightness();
		if ($urandom_range(0, 7) == 0)
			return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		return rfts_pkg::LEVEL_W'($urandom_range(0, 255));
	endfunction

	// One random phase: wait for idle, write every register, then queue random ticks.
	task automatic random_phase(input logic [1:0] mode, input int unsigned count, input bit calm);
		drain();
		write_reg(rfts_pkg::REG_LIGHT_MODE, rfts_pkg::PERIOD_W'(mode));
		write_reg(rfts_pkg::REG_PWM_PERIOD, pick_period());
		write_reg(rfts_pkg::REG_SCALE_MAX, rfts_pkg::PERIOD_W'(pick_byte()));
		write_reg(rfts_pkg::REG_RED_GAIN, rfts_pkg::PERIOD_W'(pick_byte()));
		write_reg(rfts_pkg::REG_GREEN_GAIN, rfts_pkg::PERIOD_W'(pick_byte()));
		write_reg(rfts_pkg::REG_BLUE_GAIN, rfts_pkg::PERIOD_W'(pick_byte()));
		@(posedge clk);
		quiet = calm;
		repeat (count) tick_q.push_back(pick_brightness());
	endtask

	initial begin
		logic [1:0] plan [12];
		plan = '{rfts_pkg::MODE_FADE, rfts_pkg::MODE_STROBE, rfts_pkg::MODE_FADE, MODE_IDLE,
			rfts_pkg::MODE_FADE, rfts_pkg::MODE_FADE, MODE_SPARE, rfts_pkg::MODE_FADE,
			rfts_pkg::MODE_FADE, rfts_pkg::MODE_STROBE, rfts_pkg::MODE_FADE,
			rfts_pkg::MODE_FADE};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fade with the reset values of period, scale and gains, brightness at its extremes.
		write_reg(rfts_pkg::REG_LIGHT_MODE, rfts_pkg::PERIOD_W'(rfts_pkg::MODE_FADE));
		@(posedge clk);
		tick_q = {8'h00, 8'hFF, 8'h55, 8'hAA};

		// Largest period and gains with the smallest scale: every lit channel saturates.
		drain();
		write_reg(rfts_pkg::REG_PWM_PERIOD, 16'hFFFF);
		write_reg(rfts_pkg::REG_SCALE_MAX, 16'h0001);
		write_reg(rfts_pkg::REG_RED_GAIN, 16'h00FF);
		write_reg(rfts_pkg::REG_GREEN_GAIN, 16'h00FF);
		write_reg(rfts_pkg::REG_BLUE_GAIN, 16'h00FF);
		@(posedge clk);
		tick_q = {8'hFF, 8'h01, 8'h80};

		// A zero scale_max must act as one; gains at zero, middle and full scale.
		drain();
		write_reg(rfts_pkg::REG_PWM_PERIOD, 16'd1000);
		write_reg(rfts_pkg::REG_SCALE_MAX, 16'h0000);
		write_reg(rfts_pkg::REG_RED_GAIN, 16'h0000);
		write_reg(rfts_pkg::REG_GREEN_GAIN, 16'h0080);
		@(posedge clk);
		tick_q = {8'hFF, 8'hC8};

		// Outside fade the wheel holds and duties read zero, in both of the plain modes.
		drain();
		write_reg(rfts_pkg::REG_LIGHT_MODE, rfts_pkg::PERIOD_W'(MODE_IDLE));
		@(posedge clk);
		tick_q = {8'h12, 8'hED, 8'h00};
		drain();
		write_reg(rfts_pkg::REG_LIGHT_MODE, rfts_pkg::PERIOD_W'(MODE_SPARE));
		@(posedge clk);
		tick_q = {8'hFF, 8'h3C};

		// Strobe across the divider wrap, where value_changed fires with new_sample.
		drain();
		write_reg(rfts_pkg::REG_LIGHT_MODE, rfts_pkg::PERIOD_W'(rfts_pkg::MODE_STROBE));
		@(posedge clk);
		repeat (11) tick_q.push_back(pick_brightness());

		// Random phases; fade dominates so the wheel runs through its wrap.
		foreach (plan[i])
			random_phase(plan[i], (plan[i] == rfts_pkg::MODE_FADE) ? FADE_TICKS : OTHER_TICKS,
				(i % 3) == 2);

		drain();
		if (n_fail == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
